// File: rtl/core/opui_pkg.sv
package opui_pkg;

    // Fixed formats
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    localparam int ATAN_IDX_W       = 5;
    localparam int PC_W             = 4;
    localparam int CFG_IDX_W        = 8;
    localparam int MUL_W            = 33;
    localparam int PROD_W           = 2 * MUL_W;

    localparam logic signed [31:0] INV_GAIN_Q30  = 32'sd652032874;
    localparam logic        [30:0] STEP_TIME_RST = 31'd6554;
    localparam logic signed [PROD_W-1:0] S32_MAX = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] S32_MIN = -PROD_W'(64'sd2147483648);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_POINT_OFFSET = CFG_IDX_W'(1);

    // Control word fields
    typedef enum logic [2:0] {
        J_NEXT, J_ALWAYS, J_NOIN, J_START, J_BUSY, J_OFULL
    } t_jmp;

    typedef enum logic [2:0] {
        MA_B, MA_V, MA_BW, MA_XR, MA_YR
    } t_ma;

    typedef enum logic [1:0] {
        MB_W, MB_C, MB_S, MB_DT
    } t_mb;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
    } t_acc;

    typedef enum logic [1:0] {
        AW_NONE, AW_BW, AW_XR, AW_YR
    } t_awr;

    typedef enum logic [2:0] {
        PW_NONE, PW_BEGIN, PW_PX, PW_PY, PW_EMIT
    } t_pwr;

    typedef struct packed {
        t_jmp            jmp;
        logic [PC_W-1:0] target;
        logic            in_rdy;
        logic            cordic_go;
        t_ma             ma;
        t_mb             mb;
        t_acc            acc;
        t_awr            awr;
        t_pwr            pwr;
    } t_uop;

    typedef struct packed {
        logic in_valid;
        logic is_start;
        logic cordic_busy;
        logic out_full;
    } t_stat;

    // Build one control word
    function automatic t_uop uop(t_jmp j, logic [PC_W-1:0] tgt, logic rdy, logic go,
                                 t_ma ma, t_mb mb, t_acc acc, t_awr awr, t_pwr pwr);
        t_uop u;
        u.jmp       = j;
        u.target    = tgt;
        u.in_rdy    = rdy;
        u.cordic_go = go;
        u.ma        = ma;
        u.mb        = mb;
        u.acc       = acc;
        u.awr       = awr;
        u.pwr       = pwr;
        return u;
    endfunction

    // Microprogram: one pose update per pass
    function automatic t_uop uc_rom(logic [PC_W-1:0] pc);
        t_uop u;
        u = uop(J_NEXT, '0, 1'b0, 1'b0, MA_B, MB_W, ACC_HOLD, AW_NONE, PW_NONE);
        unique case (pc)
            4'd0:  u = uop(J_NOIN, 4'd0, 1'b1, 1'b0, MA_B, MB_W, ACC_HOLD, AW_NONE, PW_NONE);
            4'd1:  u = uop(J_START, 4'd14, 1'b0, 1'b0, MA_B, MB_W, ACC_HOLD, AW_NONE,
                           PW_BEGIN);
            4'd2:  u = uop(J_NEXT, '0, 1'b0, 1'b1, MA_B, MB_W, ACC_HOLD, AW_NONE, PW_NONE);
            4'd3:  u = uop(J_NEXT, '0, 1'b0, 1'b0, MA_B, MB_W, ACC_LOAD, AW_NONE, PW_NONE);
            4'd4:  u = uop(J_NEXT, '0, 1'b0, 1'b0, MA_B, MB_W, ACC_HOLD, AW_BW, PW_NONE);
            4'd5:  u = uop(J_BUSY, 4'd5, 1'b0, 1'b0, MA_V, MB_C, ACC_HOLD, AW_NONE, PW_NONE);
            4'd6:  u = uop(J_NEXT, '0, 1'b0, 1'b0, MA_V, MB_C, ACC_HOLD, AW_NONE, PW_NONE);
            4'd7:  u = uop(J_NEXT, '0, 1'b0, 1'b0, MA_BW, MB_S, ACC_LOAD, AW_NONE, PW_NONE);
            4'd8:  u = uop(J_NEXT, '0, 1'b0, 1'b0, MA_V, MB_S, ACC_SUB, AW_NONE, PW_NONE);
            4'd9:  u = uop(J_NEXT, '0, 1'b0, 1'b0, MA_BW, MB_C, ACC_LOAD, AW_XR, PW_NONE);
            4'd10: u = uop(J_NEXT, '0, 1'b0, 1'b0, MA_XR, MB_DT, ACC_ADD, AW_NONE, PW_NONE);
            4'd11: u = uop(J_NEXT, '0, 1'b0, 1'b0, MA_YR, MB_DT, ACC_HOLD, AW_YR, PW_PX);
            4'd12: u = uop(J_NEXT, '0, 1'b0, 1'b0, MA_YR, MB_DT, ACC_HOLD, AW_NONE, PW_NONE);
            4'd13: u = uop(J_NEXT, '0, 1'b0, 1'b0, MA_B, MB_W, ACC_HOLD, AW_NONE, PW_PY);
            4'd14: u = uop(J_OFULL, 4'd14, 1'b0, 1'b0, MA_B, MB_W, ACC_HOLD, AW_NONE,
                           PW_EMIT);
            4'd15: u = uop(J_ALWAYS, 4'd0, 1'b0, 1'b0, MA_B, MB_W, ACC_HOLD, AW_NONE,
                           PW_NONE);
            default: u = uop(J_ALWAYS, 4'd0, 1'b0, 1'b0, MA_B, MB_W, ACC_HOLD, AW_NONE,
                             PW_NONE);
        endcase
        return u;
    endfunction

    // Arctangent of 2^-i in 32-bit binary angle
    function automatic logic signed [31:0] atan_lut(logic [ATAN_IDX_W-1:0] i);
        logic signed [31:0] a;
        unique case (i)
            5'd0:  a = 32'sh20000000;
            5'd1:  a = 32'sh12E4051E;
            5'd2:  a = 32'sh09FB385B;
            5'd3:  a = 32'sh051111D4;
            5'd4:  a = 32'sh028B0D43;
            5'd5:  a = 32'sh0145D7E1;
            5'd6:  a = 32'sh00A2F61E;
            5'd7:  a = 32'sh00517C55;
            5'd8:  a = 32'sh0028BE53;
            5'd9:  a = 32'sh00145F2F;
            5'd10: a = 32'sh000A2F98;
            5'd11: a = 32'sh000517CC;
            5'd12: a = 32'sh00028BE6;
            5'd13: a = 32'sh000145F3;
            5'd14: a = 32'sh0000A2FA;
            5'd15: a = 32'sh0000517D;
            5'd16: a = 32'sh000028BE;
            5'd17: a = 32'sh0000145F;
            5'd18: a = 32'sh00000A30;
            5'd19: a = 32'sh00000518;
            5'd20: a = 32'sh0000028C;
            5'd21: a = 32'sh00000146;
            5'd22: a = 32'sh000000A3;
            5'd23: a = 32'sh00000051;
            default: a = 32'sh0;
        endcase
        return a;
    endfunction

    // Clip a wide value to 32-bit signed
    function automatic logic signed [31:0] sat32(logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < S32_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic ovf32(logic signed [PROD_W-1:0] v);
        return (v > S32_MAX) || (v < S32_MIN);
    endfunction

endpackage

// File: rtl/core/opui_if.sv
// Sample channel
interface opui_smp_if;
    logic               valid;
    logic               ready;
    logic               start_req;
    logic signed [31:0] speed;
    logic signed [15:0] turn_step;
    logic signed [31:0] init_x;
    logic signed [31:0] init_y;
    logic        [15:0] init_heading;

    modport source (output valid, start_req, speed, turn_step, init_x, init_y,
                    init_heading, input ready);
    modport sink   (input valid, start_req, speed, turn_step, init_x, init_y,
                    init_heading, output ready);
endinterface

// Pose channel
interface opui_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] heading;
    logic signed [31:0] x_rate;
    logic signed [31:0] y_rate;
    logic               saturated;

    modport source (output valid, pos_x, pos_y, heading, x_rate, y_rate, saturated,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, heading, x_rate, y_rate, saturated,
                    output ready);
endinterface

// Register write channel
interface opui_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [opui_pkg::CFG_IDX_W-1:0]  index;
    logic [31:0]                     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/opui_seq.sv
module opui_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  opui_pkg::t_stat i_stat,
    output opui_pkg::t_uop  o_uop
);

    logic [opui_pkg::PC_W-1:0] r_pc;
    logic [opui_pkg::PC_W-1:0] n_pc;
    opui_pkg::t_uop            s_uop;
    logic                      s_take;

    // Fetch the control word
    assign s_uop = opui_pkg::uc_rom(r_pc);
    assign o_uop = s_uop;

    // Evaluate the jump condition
    always_comb begin
        unique case (s_uop.jmp)
            opui_pkg::J_NEXT:   s_take = 1'b0;
            opui_pkg::J_ALWAYS: s_take = 1'b1;
            opui_pkg::J_NOIN:   s_take = !i_stat.in_valid;
            opui_pkg::J_START:  s_take = i_stat.is_start;
            opui_pkg::J_BUSY:   s_take = i_stat.cordic_busy;
            opui_pkg::J_OFULL:  s_take = i_stat.out_full;
            default:            s_take = 1'b1;
        endcase
        n_pc = s_take ? s_uop.target : r_pc + 1'b1;
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// File: rtl/core/opui_cordic.sv
module opui_cordic #(
    parameter int CORDIC_STEPS = opui_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic        [15:0] i_angle,
    output logic               o_busy,
    output logic signed [31:0] o_cos,
    output logic signed [31:0] o_sin
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);

    logic               r_busy;
    logic               r_flip;
    logic [CNT_W-1:0]   r_i;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] n_x;
    logic signed [31:0] n_y;
    logic signed [31:0] n_z;
    logic signed [31:0] s_atan;
    logic        [31:0] s_a;
    logic               s_fold;
    logic               s_last;

    // Fold the angle into the right half plane
    assign s_a    = {i_angle, 16'h0000};
    assign s_fold = s_a[31] ^ s_a[30];
    assign s_atan = opui_pkg::atan_lut(opui_pkg::ATAN_IDX_W'(r_i));
    assign s_last = (r_i == CNT_W'(CORDIC_STEPS - 1));

    // One micro-rotation
    always_comb begin
        if (!r_z[31]) begin
            n_x = r_x - (r_y >>> r_i);
            n_y = r_y + (r_x >>> r_i);
            n_z = r_z - s_atan;
        end else begin
            n_x = r_x + (r_y >>> r_i);
            n_y = r_y - (r_x >>> r_i);
            n_z = r_z + s_atan;
        end
    end

    // Load, iterate, unfold on the last step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_go) begin
            r_busy <= 1'b1;
        end else if (r_busy && s_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_i    <= '0;
            r_flip <= s_fold;
            r_x    <= opui_pkg::INV_GAIN_Q30;
            r_y    <= '0;
            r_z    <= s_fold ? {~s_a[31], s_a[30:0]} : s_a;
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            r_z <= n_z;
            if (s_last && r_flip) begin
                r_x <= -n_x;
                r_y <= -n_y;
            end else begin
                r_x <= n_x;
                r_y <= n_y;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_cos  = r_x;
    assign o_sin  = r_y;

    // A new rotation never starts over one in flight
    a_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go |-> !r_busy)
        else $error("cordic started while busy");

    // A rotation ends only after the full step count
    a_full_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> $past(r_i) == CNT_W'(CORDIC_STEPS - 1))
        else $error("cordic ended early");

endmodule

// File: rtl/core/opui_dp.sv
module opui_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  opui_pkg::t_uop                  i_uop,
    // sample word
    input  logic                            i_in_acc,
    input  logic                            i_start_req,
    input  logic signed [31:0]              i_speed,
    input  logic signed [15:0]              i_turn_step,
    input  logic signed [31:0]              i_init_x,
    input  logic signed [31:0]              i_init_y,
    input  logic        [15:0]              i_init_heading,
    // register writes
    input  logic                            i_cfg_we,
    input  logic [opui_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    // rotation unit
    input  logic signed [31:0]              i_cos,
    input  logic signed [31:0]              i_sin,
    output logic        [15:0]              o_angle,
    output logic                            o_is_start,
    // pose word
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic signed [31:0]              o_pos_x,
    output logic signed [31:0]              o_pos_y,
    output logic        [15:0]              o_heading,
    output logic signed [31:0]              o_x_rate,
    output logic signed [31:0]              o_y_rate,
    output logic                            o_saturated
);

    localparam int PW = opui_pkg::PROD_W;
    localparam int MW = opui_pkg::MUL_W;

    logic        [30:0] r_dt;
    logic signed [31:0] r_b;
    logic               r_start;
    logic signed [31:0] r_v;
    logic signed [15:0] r_w;
    logic signed [31:0] r_ix;
    logic signed [31:0] r_iy;
    logic        [15:0] r_ih;
    logic signed [31:0] r_cx;
    logic signed [31:0] r_cy;
    logic        [15:0] r_ch;
    logic signed [31:0] r_bw;
    logic signed [31:0] r_xr;
    logic signed [31:0] r_yr;
    logic               r_hit;
    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] r_acc;
    logic               r_ovalid;
    logic signed [MW-1:0] s_ma;
    logic signed [MW-1:0] s_mb;
    logic signed [PW-1:0] n_prod;
    logic signed [PW-1:0] s_rate;
    logic signed [PW-1:0] s_npos;
    logic signed [31:0]   s_cur;
    logic               s_emit;

    // Hold the registers written over the write channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= opui_pkg::STEP_TIME_RST;
            r_b  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == opui_pkg::REG_STEP_TIME) begin
                r_dt <= i_cfg_data[30:0];
            end else if (i_cfg_index == opui_pkg::REG_POINT_OFFSET) begin
                r_b <= i_cfg_data;
            end
        end
    end

    // Capture the sample word
    always_ff @(posedge i_clk) begin
        if (i_in_acc) begin
            r_start <= i_start_req;
            r_v     <= i_speed;
            r_w     <= i_turn_step;
            r_ix    <= i_init_x;
            r_iy    <= i_init_y;
            r_ih    <= i_init_heading;
        end
    end

    // Shared multiplier operands
    always_comb begin
        case (i_uop.ma)
            opui_pkg::MA_B:  s_ma = MW'(r_b);
            opui_pkg::MA_V:  s_ma = MW'(r_v);
            opui_pkg::MA_BW: s_ma = MW'(r_bw);
            opui_pkg::MA_XR: s_ma = MW'(r_xr);
            opui_pkg::MA_YR: s_ma = MW'(r_yr);
            default:         s_ma = '0;
        endcase
        case (i_uop.mb)
            opui_pkg::MB_W:  s_mb = MW'(r_w);
            opui_pkg::MB_C:  s_mb = MW'(i_cos);
            opui_pkg::MB_S:  s_mb = MW'(i_sin);
            opui_pkg::MB_DT: s_mb = signed'({{(MW - 31){1'b0}}, r_dt});
            default:         s_mb = '0;
        endcase
    end

    assign n_prod = s_ma * s_mb;

    // Register the product, then accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        case (i_uop.acc)
            opui_pkg::ACC_LOAD: r_acc <= r_prod;
            opui_pkg::ACC_ADD:  r_acc <= r_acc + r_prod;
            opui_pkg::ACC_SUB:  r_acc <= r_acc - r_prod;
            default:            r_acc <= r_acc;
        endcase
    end

    // Write back turn term and rates from the accumulator
    assign s_rate = r_acc >>> 30;

    always_ff @(posedge i_clk) begin
        case (i_uop.awr)
            opui_pkg::AW_BW: r_bw <= opui_pkg::sat32(r_acc);
            opui_pkg::AW_XR: r_xr <= opui_pkg::sat32(s_rate);
            opui_pkg::AW_YR: r_yr <= opui_pkg::sat32(s_rate);
            default: ;
        endcase
        if (i_uop.pwr == opui_pkg::PW_BEGIN && r_start) begin
            r_xr <= '0;
            r_yr <= '0;
        end
    end

    // Position step: add rate*dt to the current coordinate
    assign s_cur  = (i_uop.pwr == opui_pkg::PW_PY) ? r_cy : r_cx;
    assign s_npos = PW'(s_cur) + (r_prod >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_ch <= '0;
        end else begin
            case (i_uop.pwr)
                opui_pkg::PW_BEGIN: begin
                    if (r_start) begin
                        r_cx <= r_ix;
                        r_cy <= r_iy;
                        r_ch <= r_ih;
                    end else begin
                        r_ch <= r_ch + r_w;
                    end
                end
                opui_pkg::PW_PX: r_cx <= opui_pkg::sat32(s_npos);
                opui_pkg::PW_PY: r_cy <= opui_pkg::sat32(s_npos);
                default: ;
            endcase
        end
    end

    // Track position clipping for this word
    always_ff @(posedge i_clk) begin
        case (i_uop.pwr)
            opui_pkg::PW_BEGIN: r_hit <= 1'b0;
            opui_pkg::PW_PX,
            opui_pkg::PW_PY:    r_hit <= r_hit | opui_pkg::ovf32(s_npos);
            default: ;
        endcase
    end

    // Output register: load when free or draining this cycle
    assign s_emit = (i_uop.pwr == opui_pkg::PW_EMIT) && (!r_ovalid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (s_emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_emit) begin
            o_pos_x     <= r_cx;
            o_pos_y     <= r_cy;
            o_heading   <= r_ch;
            o_x_rate    <= r_xr;
            o_y_rate    <= r_yr;
            o_saturated <= r_hit;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_angle     = r_ch;
    assign o_is_start  = r_start;

endmodule

// File: rtl/core/offset_unicycle_pose_integrator.sv
// Channel  Dir  Handshake       Word
// i_smp    in   valid / ready   start_req, speed, turn_step, init_x, init_y, init_heading
// o_pose   out  valid / ready   pos_x, pos_y, heading, x_rate, y_rate, saturated
// i_cfg    in   valid / ready   index, data (0 step_time, 1 point_offset)
//
// A motion sample's processing time is set by the iterative CORDIC rotation;
// a start sample skips the rotation.
// One sample is in work at a time; the next is taken while the result waits.
// Reset is synchronous, active low; it clears the pose and loads the register defaults.
// Register writes are always taken; a stalled pose word holds the microprogram.
module offset_unicycle_pose_integrator #(
    parameter int CORDIC_STEPS = opui_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    opui_smp_if.sink    i_smp,
    opui_pose_if.source o_pose,
    opui_cfg_if.sink    i_cfg
);

    opui_pkg::t_uop     s_uop;
    opui_pkg::t_stat    s_stat;
    logic               s_in_acc;
    logic               s_busy;
    logic               s_is_start;
    logic        [15:0] s_angle;
    logic signed [31:0] s_cos;
    logic signed [31:0] s_sin;

    // Handshakes
    assign i_smp.ready = s_uop.in_rdy;
    assign s_in_acc    = i_smp.valid && s_uop.in_rdy;
    assign i_cfg.ready = 1'b1;

    assign s_stat.in_valid    = i_smp.valid;
    assign s_stat.is_start    = s_is_start;
    assign s_stat.cordic_busy = s_busy;
    assign s_stat.out_full    = o_pose.valid && !o_pose.ready;

    opui_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (s_stat),
        .o_uop   (s_uop)
    );

    opui_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (s_uop.cordic_go),
        .i_angle (s_angle),
        .o_busy  (s_busy),
        .o_cos   (s_cos),
        .o_sin   (s_sin)
    );

    opui_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_uop          (s_uop),
        .i_in_acc       (s_in_acc),
        .i_start_req    (i_smp.start_req),
        .i_speed        (i_smp.speed),
        .i_turn_step    (i_smp.turn_step),
        .i_init_x       (i_smp.init_x),
        .i_init_y       (i_smp.init_y),
        .i_init_heading (i_smp.init_heading),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_cos          (s_cos),
        .i_sin          (s_sin),
        .o_angle        (s_angle),
        .o_is_start     (s_is_start),
        .i_out_ready    (o_pose.ready),
        .o_out_valid    (o_pose.valid),
        .o_pos_x        (o_pose.pos_x),
        .o_pos_y        (o_pose.pos_y),
        .o_heading      (o_pose.heading),
        .o_x_rate       (o_pose.x_rate),
        .o_y_rate       (o_pose.y_rate),
        .o_saturated    (o_pose.saturated)
    );

    // One sample at a time: ready drops right after a word is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> !i_smp.ready)
        else $error("sample taken while another is in work");

    // Rotation results are read only once the rotation has finished;
    // the wait step merely spins on the busy flag
    a_trig_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((s_uop.mb == opui_pkg::MB_C || s_uop.mb == opui_pkg::MB_S) &&
         (s_uop.jmp != opui_pkg::J_BUSY)) |-> !s_busy)
        else $error("cos/sin used while rotation busy");

endmodule
